@@ hw/rtl/rgpt_pkg.sv @@
// shared types and constants for the rain gauge period totals block
`default_nettype none
package rgpt_pkg;
	localparam logic [3:0] MARK_UNSET = 4'd15;
	localparam logic [3:0] RST_ALL = 4'hF;
	localparam int CFG_GAUGE_WRAP = 0;
	localparam int CFG_QUALITY = 1;

	typedef struct packed {
		logic        mode;
		logic [31:0] timestamp;
		logic [5:0]  minute;
		logic [2:0]  weekday;
		logic [3:0]  month;
		logic [19:0] rain_count;
		logic        startup;
		logic [3:0]  reset_flags;
	} in_item_t;

	typedef struct packed {
		logic [20:0] hour_rain;
		logic [5:0]  valid_bins;
		logic        hour_valid;
		logic [31:0] day_rain;
		logic        day_known;
		logic [31:0] week_rain;
		logic        week_known;
		logic [31:0] month_rain;
		logic        month_known;
		logic        time_rejected;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic fold;
		logic update;
		logic sum_clr;
		logic sum_step;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic sum_done;
	} dp_sts_t;

	function automatic logic [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) return 16'h7FFF;
		else if (v < -34'sd32768) return 16'h8000;
		else return v[15:0];
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/rgpt_if.sv @@
// valid/ready channel carrying one item
`default_nettype none
interface rgpt_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rgpt_ctrl.sv @@
// sequencing state machine
`default_nettype none
module rgpt_ctrl
	import rgpt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  dp_sts_t      sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FOLD = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_FOLD: cmd.fold = 1'b1;
			S_UPD: begin
				cmd.update = 1'b1;
				cmd.sum_clr = sts.walk_done;
			end
			S_SUM: cmd.sum_step = 1'b1;
			S_EMIT: cmd.emit = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken at the same edge
			if (out_valid_q && out_ready && !cmd.emit) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_FOLD;
				S_FOLD: state_q <= S_UPD;
				S_UPD: if (sts.walk_done) state_q <= S_SUM;
				S_SUM: if (sts.sum_done) state_q <= S_EMIT;
				S_EMIT: if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/rgpt_dp.sv @@
// totals folding, bin ring, baselines and output register
`default_nettype none
module rgpt_dp
	import rgpt_pkg::*;
#(
	parameter int SLOT_MINUTES = 6,
	parameter int HIST_SLOTS = 10
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  in_item_t     in_data,
	input  wire logic    cfg_we,
	input  wire logic    cfg_index,
	input  wire logic [20:0] cfg_data,
	input  dp_cmd_t      cmd,
	output dp_sts_t      sts,
	output out_item_t    out_data
);
	localparam int SW = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
	localparam int CW = $clog2(HIST_SLOTS + 1);
	localparam logic [33:0] SLOT_SEC = 34'(SLOT_MINUTES * 60);
	localparam logic [33:0] RING_SEC = 34'(HIST_SLOTS * SLOT_MINUTES * 60);
	localparam logic [SW-1:0] LAST = SW'(HIST_SLOTS - 1);

	logic [20:0] gauge_wrap_q;
	logic [5:0]  quality_q;
	in_item_t    it_q;
	logic [15:0] bins_q [HIST_SLOTS];
	logic [31:0] last_time_q, prev_total_q, wrap_offset_q, running_total_q;
	logic [SW-1:0] last_slot_q, slot_q, walk_q, sidx_q;
	logic        prev_known_q, startup_before_q, rejected_q, walking_q;
	logic [19:0] reading_before_q;
	logic [3:0]  day_mark_q, week_mark_q, month_mark_q, wday_before_q;
	logic [31:0] day_base_q, week_base_q, month_base_q;
	logic [15:0] delta_q;
	logic [33:0] tdelta_q, tnext_q;
	logic [20:0] sum_q;
	logic [CW-1:0] cnt_q;
	out_item_t   out_q;

	// fold stage values
	logic [31:0] pt, lt, total0, woff, total;
	logic [SW-1:0] ls;
	logic [SW-1:0] slot_c;

	// minute to slot as a constant table
	always_comb begin
		slot_c = '0;
		for (int m = 0; m < 64; m++)
			if (in_data.minute == 6'(m)) slot_c = SW'((m / SLOT_MINUTES) % HIST_SLOTS);
	end

	always_comb begin
		pt = prev_known_q ? prev_total_q : 32'(it_q.rain_count);
		lt = prev_known_q ? last_time_q : it_q.timestamp;
		ls = prev_known_q ? last_slot_q : slot_q;
		total0 = wrap_offset_q + 32'(it_q.rain_count);
		woff = wrap_offset_q;
		if (total0 < pt) begin
			if (!startup_before_q && it_q.startup) woff = wrap_offset_q + 32'(reading_before_q);
			else woff = wrap_offset_q + 32'(gauge_wrap_q);
		end
		total = woff + 32'(it_q.rain_count);
	end

	logic [SW-1:0] walk_nx;
	assign walk_nx = (walk_q == LAST) ? '0 : walk_q + 1'b1;
	assign sts.walk_done = !walking_q || !(tnext_q < 34'(it_q.timestamp));
	assign sts.sum_done = (sidx_q == LAST);

	logic [15:0] cur;
	assign cur = bins_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gauge_wrap_q <= 21'd100000;
			quality_q <= 6'd10;
			for (int i = 0; i < HIST_SLOTS; i++) bins_q[i] <= 16'hFFFF;
			last_time_q <= '0; last_slot_q <= '0; prev_total_q <= '0;
			prev_known_q <= 1'b1; wrap_offset_q <= '0; running_total_q <= '0;
			startup_before_q <= 1'b0; reading_before_q <= '0;
			day_mark_q <= MARK_UNSET; week_mark_q <= MARK_UNSET;
			month_mark_q <= MARK_UNSET; wday_before_q <= MARK_UNSET;
			day_base_q <= '0; week_base_q <= '0; month_base_q <= '0;
			walking_q <= 1'b0; rejected_q <= 1'b0;
			it_q <= '0; slot_q <= '0; walk_q <= '0; delta_q <= '0;
			tdelta_q <= '0; tnext_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(CFG_GAUGE_WRAP)) gauge_wrap_q <= cfg_data;
				else quality_q <= cfg_data[5:0];
			end
			if (cmd.load) begin
				it_q <= in_data;
				slot_q <= slot_c;
			end
			if (cmd.fold) begin
				rejected_q <= 1'b0;
				walking_q <= 1'b0;
				if (it_q.mode) begin
					if (it_q.reset_flags[0])
						for (int i = 0; i < HIST_SLOTS; i++) bins_q[i] <= 16'hFFFF;
					if (it_q.reset_flags[1]) begin day_mark_q <= MARK_UNSET; day_base_q <= '0; end
					if (it_q.reset_flags[2]) begin week_mark_q <= MARK_UNSET; week_base_q <= '0; end
					if (it_q.reset_flags[3]) begin month_mark_q <= MARK_UNSET; month_base_q <= '0; end
					if (it_q.reset_flags == RST_ALL) begin
						startup_before_q <= 1'b0; reading_before_q <= '0;
						prev_total_q <= '0; prev_known_q <= 1'b0;
						wrap_offset_q <= '0; running_total_q <= '0;
					end
				end else begin
					if (last_time_q == '0)
						for (int i = 0; i < HIST_SLOTS; i++) bins_q[i] <= 16'hFFFF;
					prev_total_q <= pt; last_time_q <= lt; last_slot_q <= ls;
					prev_known_q <= 1'b1;
					wrap_offset_q <= woff; running_total_q <= total;
					startup_before_q <= it_q.startup; reading_before_q <= it_q.rain_count;
					delta_q <= sat16(34'(signed'({2'b00, total})) - 34'(signed'({2'b00, pt})));
					if (wday_before_q == MARK_UNSET) wday_before_q <= {1'b0, it_q.weekday};
					tdelta_q <= 34'(it_q.timestamp) - 34'(lt);
					tnext_q <= 34'(lt) + SLOT_SEC;
					walk_q <= ls;
					if (it_q.timestamp < lt) rejected_q <= 1'b1;
					else if (34'(it_q.timestamp) - 34'(lt) >= SLOT_SEC
						&& 34'(it_q.timestamp) - 34'(lt) < RING_SEC) walking_q <= 1'b1;
				end
			end
			if (cmd.update && !it_q.mode && !rejected_q) begin
				if (walking_q && !sts.walk_done) begin
					bins_q[walk_nx] <= 16'hFFFF;
					walk_q <= walk_nx;
					tnext_q <= tnext_q + SLOT_SEC;
				end else begin
					if (tdelta_q < SLOT_SEC) begin
						if (last_slot_q == slot_q)
							bins_q[slot_q] <= sat16(34'(signed'(cur[15] ? 16'd0 : cur))
								+ 34'(signed'(delta_q)));
						else bins_q[slot_q] <= delta_q;
					end else if (tdelta_q >= RING_SEC) begin
						for (int i = 0; i < HIST_SLOTS; i++) bins_q[i] <= 16'hFFFF;
					end else bins_q[slot_q] <= delta_q;
					if ({1'b0, it_q.weekday} != day_mark_q || day_mark_q == MARK_UNSET) begin
						day_mark_q <= {1'b0, it_q.weekday}; day_base_q <= running_total_q;
					end
					if ((it_q.weekday == 3'd1 && wday_before_q == 4'd0) || week_mark_q == MARK_UNSET) begin
						week_mark_q <= {1'b0, it_q.weekday}; week_base_q <= running_total_q;
					end
					wday_before_q <= {1'b0, it_q.weekday};
					if (it_q.month != month_mark_q || month_mark_q == MARK_UNSET) begin
						month_mark_q <= it_q.month; month_base_q <= running_total_q;
					end
					last_time_q <= it_q.timestamp;
					last_slot_q <= slot_q;
					prev_total_q <= running_total_q;
				end
			end
		end
	end

	// serial sum over the ring
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sidx_q <= '0; sum_q <= '0; cnt_q <= '0;
		end else if (cmd.sum_step) begin
			if (!bins_q[sidx_q][15]) begin
				sum_q <= sum_q + 21'(bins_q[sidx_q]);
				cnt_q <= cnt_q + 1'b1;
			end
			if (!sts.sum_done) sidx_q <= sidx_q + 1'b1;
		end
	end

	logic [20:0] sum_f;
	logic [CW-1:0] cnt_f;
	always_comb begin
		sum_f = sum_q; cnt_f = cnt_q;
		if (!bins_q[sidx_q][15]) begin
			sum_f = sum_q + 21'(bins_q[sidx_q]);
			cnt_f = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_step && sts.sum_done) begin
			out_q.hour_rain <= sum_f;
			out_q.valid_bins <= 6'(cnt_f);
			out_q.hour_valid <= 6'(cnt_f) >= quality_q;
			out_q.day_known <= day_mark_q != MARK_UNSET;
			out_q.day_rain <= (day_mark_q != MARK_UNSET) ? running_total_q - day_base_q : '0;
			out_q.week_known <= week_mark_q != MARK_UNSET;
			out_q.week_rain <= (week_mark_q != MARK_UNSET) ? running_total_q - week_base_q : '0;
			out_q.month_known <= month_mark_q != MARK_UNSET;
			out_q.month_rain <= (month_mark_q != MARK_UNSET) ? running_total_q - month_base_q : '0;
			out_q.time_rejected <= rejected_q;
		end
		if (cmd.emit) out_data <= out_q;
	end
endmodule
`default_nettype wire

@@ hw/rtl/rain_gauge_period_totals_core.sv @@
// Rain gauge period totals: one result item per input item. Each item is
// loaded, its counter total is folded, each skipped slot is invalidated in
// the ring walk (at most HIST_SLOTS - 1), then the bins and baselines are
// written, the bins are summed serially, and the result is presented. The
// bin ring is walked one entry per cycle; that walk and the sum set the rate,
// and a new item is taken only after the last result is presented.
`default_nettype none
module rain_gauge_period_totals_core
	import rgpt_pkg::*;
#(
	parameter int SLOT_MINUTES = 6,
	parameter int HIST_SLOTS = 10
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rgpt_if.sink       in_ch,
	rgpt_if.source     out_ch,
	input wire logic   cfg_we,
	input wire logic   cfg_index,
	input wire logic [20:0] cfg_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	rgpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	rgpt_dp #(.SLOT_MINUTES(SLOT_MINUTES), .HIST_SLOTS(HIST_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .out_data(out_ch.data)
	);
endmodule
`default_nettype wire

@@ hw/rtl/rgpt_checker.sv @@
// port-level checks bound to the top level
`default_nettype none
module rgpt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("item overlap");
	a_no_quick_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("result too early");
endmodule

bind rain_gauge_period_totals_core rgpt_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire

@@ sim/rain_gauge_period_totals_core_tb.sv @@
// testbench for the rain gauge period totals core: directed and random items checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module rain_gauge_period_totals_core_tb;
	import rgpt_pkg::*;

	localparam int SLOT_MIN = 6;
	localparam int RING = 10;
	localparam int SLOT_SEC = SLOT_MIN * 60;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [20:0] cfg_data = '0;

	rgpt_if #(.T(in_item_t)) in_ch (clk);
	rgpt_if #(.T(out_item_t)) out_ch (clk);

	rain_gauge_period_totals_core #(.SLOT_MINUTES(SLOT_MIN), .HIST_SLOTS(RING)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [20:0] wrap_val;
	logic [5:0] min_bins;
	logic signed [15:0] ring_bin [RING];
	logic [31:0] last_ts, prior_total, offset_acc, total_now, reading_prev;
	logic [3:0] last_slot_q, day_mk, week_mk, month_mk, wday_prev;
	logic [31:0] day_bs, week_bs, month_bs;
	logic total_known, startup_prev;

	in_item_t pending_items[$];
	out_item_t expected_totals[$];
	int fails = 0;
	int cycles = 0;
	bit stim_done = 0;
	int drv_gap = 0;
	int mon_gap = 0;

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic void clear_ring();
		for (int i = 0; i < RING; i++) ring_bin[i] = -16'sd1;
	endfunction

	task automatic predict_reset_state();
		wrap_val = 21'd100000;
		min_bins = 6'd10;
		clear_ring();
		last_ts = '0; last_slot_q = '0; prior_total = '0; total_known = 1'b1;
		offset_acc = '0; total_now = '0; startup_prev = 1'b0; reading_prev = '0;
		day_mk = MARK_UNSET; week_mk = MARK_UNSET; month_mk = MARK_UNSET;
		wday_prev = MARK_UNSET;
		day_bs = '0; week_bs = '0; month_bs = '0;
	endtask

	function automatic void apply_update(in_item_t it, output logic rej);
		logic [3:0] slot;
		logic [31:0] tot;
		logic signed [15:0] dlt;
		longint td, tw;
		logic [3:0] s;
		slot = 4'((it.minute / SLOT_MIN) % RING);
		rej = 1'b0;
		if (last_ts == 0) clear_ring();
		if (!total_known) begin
			prior_total = {12'd0, it.rain_count};
			total_known = 1'b1;
			last_ts = it.timestamp;
			last_slot_q = slot;
		end
		tot = offset_acc + 32'(it.rain_count);
		if (tot < prior_total) begin
			if (!startup_prev && it.startup) offset_acc += reading_prev;
			else offset_acc += 32'(wrap_val);
		end
		tot = offset_acc + 32'(it.rain_count);
		total_now = tot;
		startup_prev = it.startup;
		reading_prev = 32'(it.rain_count);
		dlt = clamp16(longint'(tot) - longint'(prior_total));
		if (wday_prev == MARK_UNSET) wday_prev = {1'b0, it.weekday};
		td = longint'(it.timestamp) - longint'(last_ts);
		if (td < 0) begin
			rej = 1'b1;
			return;
		end
		if (td < SLOT_SEC) begin
			if (ring_bin[slot] < 0) ring_bin[slot] = '0;
			if (last_slot_q % RING == slot)
				ring_bin[slot] = clamp16(longint'(ring_bin[slot]) + dlt);
			else
				ring_bin[slot] = dlt;
		end else if (td >= RING * SLOT_SEC) begin
			clear_ring();
		end else begin
			tw = longint'(last_ts) + SLOT_SEC;
			s = 4'(last_slot_q % RING);
			while (tw < longint'(it.timestamp)) begin
				s = 4'((s + 1) % RING);
				ring_bin[s] = -16'sd1;
				tw += SLOT_SEC;
			end
			ring_bin[slot] = dlt;
		end
		if ({1'b0, it.weekday} != day_mk || day_mk == MARK_UNSET) begin
			day_mk = {1'b0, it.weekday}; day_bs = tot;
		end
		if ((it.weekday == 1 && wday_prev == 0) || week_mk == MARK_UNSET) begin
			week_mk = {1'b0, it.weekday}; week_bs = tot;
		end
		wday_prev = {1'b0, it.weekday};
		if (it.month != month_mk || month_mk == MARK_UNSET) begin
			month_mk = it.month; month_bs = tot;
		end
		last_ts = it.timestamp;
		last_slot_q = slot;
		prior_total = tot;
	endfunction

	function automatic out_item_t predict_totals(in_item_t it);
		out_item_t r;
		logic rej;
		logic [31:0] sum;
		int cnt;
		rej = 1'b0; sum = '0; cnt = 0;
		if (it.mode) begin
			if (it.reset_flags[0]) clear_ring();
			if (it.reset_flags[1]) begin day_mk = MARK_UNSET; day_bs = '0; end
			if (it.reset_flags[2]) begin week_mk = MARK_UNSET; week_bs = '0; end
			if (it.reset_flags[3]) begin month_mk = MARK_UNSET; month_bs = '0; end
			if (it.reset_flags == RST_ALL) begin
				startup_prev = 1'b0; reading_prev = '0; prior_total = '0;
				total_known = 1'b0; offset_acc = '0; total_now = '0;
			end
		end else begin
			apply_update(it, rej);
		end
		for (int i = 0; i < RING; i++)
			if (ring_bin[i] >= 0) begin
				sum += 32'(ring_bin[i]);
				cnt++;
			end
		r.hour_rain = sum[20:0];
		r.valid_bins = cnt[5:0];
		r.hour_valid = cnt >= int'(min_bins);
		r.day_known = day_mk != MARK_UNSET;
		r.day_rain = r.day_known ? total_now - day_bs : 32'd0;
		r.week_known = week_mk != MARK_UNSET;
		r.week_rain = r.week_known ? total_now - week_bs : 32'd0;
		r.month_known = month_mk != MARK_UNSET;
		r.month_rain = r.month_known ? total_now - month_bs : 32'd0;
		r.time_rejected = rej;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_ch.valid && in_ch.ready) begin
			expected_totals.push_back(predict_totals(in_ch.data));
			void'(pending_items.pop_front());
			drv_gap = pick_gap();
		end
		if (arst_n && (!in_ch.valid || in_ch.ready)) begin
			if (drv_gap > 0) begin
				drv_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_items[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_r, got;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_totals.size() == 0) begin
				$error("unexpected result item %p", got);
				fails++;
			end else begin
				exp_r = expected_totals.pop_front();
				if (got.hour_rain !== exp_r.hour_rain) begin
					$error("hour_rain exp %0d got %0d", exp_r.hour_rain, got.hour_rain); fails++;
				end
				if (got.valid_bins !== exp_r.valid_bins) begin
					$error("valid_bins exp %0d got %0d", exp_r.valid_bins, got.valid_bins); fails++;
				end
				if (got.hour_valid !== exp_r.hour_valid) begin
					$error("hour_valid exp %0d got %0d", exp_r.hour_valid, got.hour_valid); fails++;
				end
				if (got.day_rain !== exp_r.day_rain) begin
					$error("day_rain exp %0d got %0d", exp_r.day_rain, got.day_rain); fails++;
				end
				if (got.day_known !== exp_r.day_known) begin
					$error("day_known exp %0d got %0d", exp_r.day_known, got.day_known); fails++;
				end
				if (got.week_rain !== exp_r.week_rain) begin
					$error("week_rain exp %0d got %0d", exp_r.week_rain, got.week_rain); fails++;
				end
				if (got.week_known !== exp_r.week_known) begin
					$error("week_known exp %0d got %0d", exp_r.week_known, got.week_known);
					fails++;
				end
				if (got.month_rain !== exp_r.month_rain) begin
					$error("month_rain exp %0d got %0d", exp_r.month_rain, got.month_rain);
					fails++;
				end
				if (got.month_known !== exp_r.month_known) begin
					$error("month_known exp %0d got %0d", exp_r.month_known, got.month_known);
					fails++;
				end
				if (got.time_rejected !== exp_r.time_rejected) begin
					$error("time_rejected exp %0d got %0d", exp_r.time_rejected,
						got.time_rejected);
					fails++;
				end
			end
		end
		if (arst_n) begin
			if (mon_gap > 0) begin
				mon_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 9) == 0) mon_gap = pick_gap();
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// stimulus state for well-formed sequences
	logic [31:0] clock_s;
	logic [2:0] wday_s;
	logic [3:0] mon_s;
	logic [19:0] cnt_s;

	function automatic in_item_t make_update(logic [31:0] ts, logic [19:0] rc, logic st);
		in_item_t it;
		it = '0;
		it.timestamp = ts;
		it.minute = 6'((ts / 60) % 60);
		it.weekday = wday_s;
		it.month = mon_s;
		it.rain_count = rc;
		it.startup = st;
		return it;
	endfunction

	task automatic push_reset(logic [3:0] f);
		in_item_t it;
		it = '0;
		it.mode = 1'b1;
		it.reset_flags = f;
		pending_items.push_back(it);
	endtask

	task automatic write_reg(int idx, logic [20:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[0];
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GAUGE_WRAP) wrap_val = val;
		else min_bins = val[5:0];
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_totals.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		in_item_t it;
		int p;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, 99);
			if (p < 75) begin
				clock_s += $urandom_range(0, 9) == 0 ? $urandom_range(360, 4000)
					: $urandom_range(0, 400);
				if ($urandom_range(0, 30) == 0) wday_s = 3'((wday_s + 1) % 7);
				if ($urandom_range(0, 60) == 0) mon_s = 4'((mon_s + 1) % 12);
				p = $urandom_range(0, 19);
				if (p == 0) cnt_s = 20'($urandom);
				else if (p == 1) cnt_s = cnt_s >> 2;
				else cnt_s = cnt_s + 20'($urandom_range(0, p < 4 ? 40000 : 300));
				pending_items.push_back(make_update(clock_s, cnt_s,
					$urandom_range(0, 7) == 0));
			end else if (p < 82) begin
				// backward time
				pending_items.push_back(make_update(clock_s - $urandom_range(1, 5000),
					20'($urandom), 1'($urandom_range(0, 1))));
			end else if (p < 90) begin
				push_reset(4'($urandom_range(0, 15)));
			end else begin
				it = '0;
				it.mode = 1'b0;
				it.timestamp = $urandom;
				it.minute = 6'($urandom_range(0, 63));
				it.weekday = 3'($urandom_range(0, 7));
				it.month = 4'($urandom_range(0, 15));
				it.rain_count = 20'($urandom);
				it.startup = 1'($urandom_range(0, 1));
				it.reset_flags = 4'($urandom_range(0, 15));
				pending_items.push_back(it);
			end
		end
	endtask

	initial begin
		predict_reset_state();
		clock_s = 32'd1000000;
		wday_s = 3'd0;
		mon_s = 4'd0;
		cnt_s = 20'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: first update, same slot, new slot, skips, long gap, wrap, startup, backward time, resets
		pending_items.push_back(make_update(clock_s, 20'd100, 1'b0));
		clock_s += 60;
		pending_items.push_back(make_update(clock_s, 20'd250, 1'b0));
		clock_s += 400;
		pending_items.push_back(make_update(clock_s, 20'd300, 1'b0));
		clock_s += 1500;
		pending_items.push_back(make_update(clock_s, 20'd50, 1'b0));
		clock_s += 30;
		pending_items.push_back(make_update(clock_s, 20'd40, 1'b1));
		clock_s += 30;
		pending_items.push_back(make_update(clock_s, 20'hFFFFF, 1'b0));
		clock_s += 3600;
		pending_items.push_back(make_update(clock_s, 20'd0, 1'b0));
		pending_items.push_back(make_update(clock_s - 10, 20'd5, 1'b0));
		wday_s = 3'd1;
		clock_s += 60;
		pending_items.push_back(make_update(clock_s, 20'd70000, 1'b0));
		mon_s = 4'd11;
		pending_items.push_back(make_update(clock_s, 20'd70010, 1'b1));
		begin
			in_item_t it;
			it = make_update(32'hFFFFFFFF, 20'd3, 1'b0);
			it.minute = 6'd63; it.month = 4'd15; it.weekday = 3'd7;
			pending_items.push_back(it);
			it.timestamp = 32'hFFFFFF00; it.minute = 6'd60;
			pending_items.push_back(it);
		end
		for (int f = 0; f < 16; f++) push_reset(f[3:0]);
		wait_idle();
		write_reg(CFG_GAUGE_WRAP, 21'd1);
		write_reg(CFG_QUALITY, 21'd0);
		clock_s = 32'd5000000;
		random_phase(250);
		wait_idle();
		write_reg(CFG_GAUGE_WRAP, 21'd1048576);
		write_reg(CFG_QUALITY, 21'd60);
		random_phase(250);
		wait_idle();
		write_reg(CFG_GAUGE_WRAP, 21'($urandom_range(1000, 500000)));
		write_reg(CFG_QUALITY, 21'd3);
		random_phase(500);
		wait_idle();
		stim_done = 1;
	end

	always @(posedge clk) begin
		if (stim_done) begin
			if (fails == 0) $display("rain_gauge_period_totals_core_tb OK");
			else $display("rain_gauge_period_totals_core_tb NOT OK");
			$finish;
		end else if (cycles > CYCLE_LIMIT) begin
			$display("rain_gauge_period_totals_core_tb NOT OK");
			$finish;
		end
	end
endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/rgpt_pkg.sv
hw/rtl/rgpt_if.sv
hw/rtl/rgpt_ctrl.sv
hw/rtl/rgpt_dp.sv
hw/rtl/rain_gauge_period_totals_core.sv
hw/rtl/rgpt_checker.sv
sim/rain_gauge_period_totals_core_tb.sv
